FILE: hw/rtl/vlce_pkg.sv
// Shared types, constants and helper functions of the coefficient encoder.
// No dependencies; every other file of the block imports this package.
package vlce_pkg;

  // Table geometry and limits.
  localparam int MAG_DEPTH  = 1024;
  localparam int RUN_DEPTH  = 64;
  localparam int SPC_DEPTH  = 8;
  localparam int CODE_WIDTH = 32;
  localparam int MAX_CODES  = 64;

  localparam int MAG_AW = (MAG_DEPTH > 1) ? $clog2(MAG_DEPTH) : 1;
  localparam int RUN_AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int SPC_AW = (SPC_DEPTH > 1) ? $clog2(SPC_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_CODES + 1) + 1;

  // Field widths of the input and output beats.
  localparam int CMD_W      = 3;
  localparam int COEF_W     = 16;
  localparam int RUN_W      = 16;
  localparam int MARKER_W   = 8;
  localparam int INDEX_W    = 10;
  localparam int ECODE_W    = 32;
  localparam int ESIZE_W    = 6;
  localparam int OUT_BITS_W = 33;
  localparam int OUT_SIZE_W = 6;
  localparam int STATUS_W   = 2;

  // Configuration registers.
  localparam int MAG_LEN_W  = 11;
  localparam int RUN_LEN_W  = 7;
  localparam int SPC_CNT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [MAG_LEN_W-1:0] MAG_LEN_RST = MAG_LEN_W'(1024);
  localparam logic [RUN_LEN_W-1:0] RUN_LEN_RST = RUN_LEN_W'(64);
  localparam logic [SPC_CNT_W-1:0] SPC_CNT_RST = SPC_CNT_W'(8);

  typedef enum logic [CMD_W-1:0] {
    CMD_COEF   = 3'd0,
    CMD_RUN    = 3'd1,
    CMD_MARKER = 3'd2,
    CMD_WR_MAG = 3'd3,
    CMD_WR_RUN = 3'd4,
    CMD_WR_SPC = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_MARKER = 2'd1,
    ST_ZERO_COEF = 2'd2,
    ST_BAD_RUN   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAG_LEN = 2'd0,
    CFG_RUN_LEN = 2'd1,
    CFG_SPC_CNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] code;
    logic [ESIZE_W-1:0]    size;
  } entry_t;

  typedef struct packed {
    logic [RUN_W-1:0] run;
    entry_t           e;
  } run_entry_t;

  typedef struct packed {
    logic [MARKER_W-1:0] marker;
    entry_t              e;
  } spc_entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [COEF_W-1:0]   coef_value;
    logic [RUN_W-1:0]    run_count;
    logic [MARKER_W-1:0] marker_id;
    logic [INDEX_W-1:0]  entry_index;
    logic [ECODE_W-1:0]  entry_code;
    logic [ESIZE_W-1:0]  entry_size;
    logic [RUN_W-1:0]    entry_run;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_BITS_W-1:0] code_bits;
    logic [OUT_SIZE_W-1:0] code_size;
    logic [STATUS_W-1:0]   status;
    logic                  last_code;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_run;
    logic emit_mag;
    logic emit_run;
    logic emit_spc;
    logic spc_step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic in_run_zero;
    logic run_last;
    logic spc_hit;
    logic spc_end;
  } dp_status_t;

  // Saturates the size of a written entry and drops code bits above it.
  function automatic entry_t fit_entry(input logic [ECODE_W-1:0] code,
                                       input logic [ESIZE_W-1:0] size);
    entry_t e;
    e.size = (int'(size) > CODE_WIDTH) ? ESIZE_W'(CODE_WIDTH) : size;
    for (int b = 0; b < CODE_WIDTH; b++) begin
      e.code[b] = code[b] && (b < int'(e.size));
    end
    return e;
  endfunction

endpackage

FILE: hw/rtl/vlce_in_if.sv
// Input channel of the coefficient encoder: valid/ready plus one command beat.
// Depends on vlce_pkg for field widths.
interface vlce_in_if;
  import vlce_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [COEF_W-1:0]   coef_value;
  logic [RUN_W-1:0]           run_count;
  logic [MARKER_W-1:0]        marker_id;
  logic [INDEX_W-1:0]         entry_index;
  logic [ECODE_W-1:0]         entry_code;
  logic [ESIZE_W-1:0]         entry_size;
  logic [RUN_W-1:0]           entry_run;

  modport source (
    output valid, cmd, coef_value, run_count, marker_id, entry_index, entry_code,
           entry_size, entry_run,
    input  ready
  );

  modport sink (
    input  valid, cmd, coef_value, run_count, marker_id, entry_index, entry_code,
           entry_size, entry_run,
    output ready
  );
endinterface

FILE: hw/rtl/vlce_out_if.sv
// Output channel of the coefficient encoder: valid/ready plus one codeword beat.
// Depends on vlce_pkg for field widths.
interface vlce_out_if;
  import vlce_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_BITS_W-1:0] code_bits;
  logic [OUT_SIZE_W-1:0] code_size;
  logic [STATUS_W-1:0]   status;
  logic                  last_code;

  modport source (
    output valid, code_bits, code_size, status, last_code,
    input  ready
  );

  modport sink (
    input  valid, code_bits, code_size, status, last_code,
    output ready
  );
endinterface

FILE: hw/rtl/vlc_coefficient_encoder.sv
// Top level of the coefficient encoder: controller plus datapath.
// Depends on vlce_pkg, vlce_in_if, vlce_out_if, vlce_ctrl and vlce_datapath.
//
//   Channel   Direction  Beat
//   in_i      sink       one command: coefficient, zero run, marker or table write
//   out_o     source     one codeword: bits, size, status, last flag
//   cfg_*     write      table lengths and special count, no handshake
//
// A coefficient is accepted with a registered magnitude table read, then emitted.
// A zero run: accept, then per codeword a run table read, then evaluation.
// A marker search checks one special entry per cycle, at most SPC_DEPTH entries.
// Table writes end at accept. Reset needs no clearing pass; tables are undefined.
// A held output beat holds back the next codeword, and no further input beat is
// accepted until that codeword has moved into the output register.
module vlc_coefficient_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vlce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vlce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  vlce_in_if.sink                         in_i,
  vlce_out_if.source                      out_o
);
  import vlce_pkg::*;

  in_beat_t   beat;
  out_beat_t  out_beat;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign beat.cmd         = in_i.cmd;
  assign beat.coef_value  = in_i.coef_value;
  assign beat.run_count   = in_i.run_count;
  assign beat.marker_id   = in_i.marker_id;
  assign beat.entry_index = in_i.entry_index;
  assign beat.entry_code  = in_i.entry_code;
  assign beat.entry_size  = in_i.entry_size;
  assign beat.entry_run   = in_i.entry_run;

  vlce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  vlce_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .beat_i      (beat),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_beat_o  (out_beat)
  );

  assign out_o.code_bits = out_beat.code_bits;
  assign out_o.code_size = out_beat.code_size;
  assign out_o.status    = out_beat.status;
  assign out_o.last_code = out_beat.last_code;

endmodule

FILE: hw/rtl/vlce_ctrl.sv
// Controller of the coefficient encoder: sequences table reads, run steps,
// marker search and codeword emission. Depends on vlce_pkg.
module vlce_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [vlce_pkg::CMD_W-1:0] in_cmd_i,
  output logic                    in_ready_o,
  input  vlce_pkg::dp_status_t    status_i,
  output vlce_pkg::dp_cmd_t       cmd_o
);
  import vlce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MAG    = 5'b00010,
    S_RUN_RD = 5'b00100,
    S_RUN_EV = 5'b01000,
    S_SPC    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_cmd_i)
            CMD_COEF:   state_d = S_MAG;
            CMD_RUN:    state_d = status_i.in_run_zero ? S_IDLE : S_RUN_RD;
            CMD_MARKER: state_d = S_SPC;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_MAG: begin
        if (status_i.out_free) begin
          cmd_o.emit_mag = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RUN_RD: begin
        cmd_o.rd_run = 1'b1;
        state_d      = S_RUN_EV;
      end
      S_RUN_EV: begin
        if (status_i.out_free) begin
          cmd_o.emit_run = 1'b1;
          state_d        = status_i.run_last ? S_IDLE : S_RUN_RD;
        end
      end
      S_SPC: begin
        if (status_i.spc_hit || status_i.spc_end) begin
          if (status_i.out_free) begin
            cmd_o.emit_spc = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.spc_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/vlce_datapath.sv
// Datapath of the coefficient encoder: configuration registers, the three code
// tables, run and search counters, and the output register. Depends on vlce_pkg.
module vlce_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vlce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vlce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  vlce_pkg::in_beat_t            beat_i,
  input  vlce_pkg::dp_cmd_t             cmd_i,
  output vlce_pkg::dp_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output vlce_pkg::out_beat_t           out_beat_o
);
  import vlce_pkg::*;

  // Configuration registers.
  logic [MAG_LEN_W-1:0] mag_len_q;
  logic [RUN_LEN_W-1:0] run_len_q;
  logic [SPC_CNT_W-1:0] spc_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_len_q <= MAG_LEN_RST;
      run_len_q <= RUN_LEN_RST;
      spc_cnt_q <= SPC_CNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAG_LEN: mag_len_q <= cfg_data_i[MAG_LEN_W-1:0];
        CFG_RUN_LEN: run_len_q <= cfg_data_i[RUN_LEN_W-1:0];
        CFG_SPC_CNT: spc_cnt_q <= cfg_data_i[SPC_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Table storage.
  entry_t     mag_mem [MAG_DEPTH];
  run_entry_t run_mem [RUN_DEPTH];
  spc_entry_t spc_tab [SPC_DEPTH];
  entry_t     mag_rd_q;
  run_entry_t run_rd_q;

  logic   wr_mag, wr_run, wr_spc, rd_mag;
  entry_t fit;

  assign fit    = fit_entry(beat_i.entry_code, beat_i.entry_size);
  assign wr_mag = cmd_i.accept && (beat_i.cmd == CMD_WR_MAG) &&
                  (int'(beat_i.entry_index) < MAG_DEPTH);
  assign wr_run = cmd_i.accept && (beat_i.cmd == CMD_WR_RUN) &&
                  (int'(beat_i.entry_index) < RUN_DEPTH);
  assign wr_spc = cmd_i.accept && (beat_i.cmd == CMD_WR_SPC) &&
                  (int'(beat_i.entry_index) < SPC_DEPTH);
  assign rd_mag = cmd_i.accept && (beat_i.cmd == CMD_COEF);

  // Coefficient magnitude and its table index.
  logic [COEF_W-1:0] mag;
  logic [MAG_AW:0]   mag_lim;
  logic [MAG_AW-1:0] mag_idx;

  always_comb begin
    mag = beat_i.coef_value[COEF_W-1] ? (~beat_i.coef_value + COEF_W'(1))
                                      : beat_i.coef_value;
    if (mag_len_q == '0) begin
      mag_lim = (MAG_AW+1)'(1);
    end else if (int'(mag_len_q) > MAG_DEPTH) begin
      mag_lim = (MAG_AW+1)'(MAG_DEPTH);
    end else begin
      mag_lim = (MAG_AW+1)'(mag_len_q);
    end
    if (int'(mag) < int'(mag_lim)) begin
      mag_idx = MAG_AW'(mag);
    end else begin
      mag_idx = MAG_AW'(mag_lim - (MAG_AW+1)'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_mag) begin
      mag_mem[MAG_AW'(beat_i.entry_index)] <= fit;
    end
    if (rd_mag) begin
      mag_rd_q <= mag_mem[mag_idx];
    end
  end

  // Zero run state.
  logic [RUN_W-1:0] rem_q;
  logic [CNT_W-1:0] n_q;
  logic [RUN_AW:0]  run_lim;
  logic [RUN_AW-1:0] run_idx;
  logic [RUN_W-1:0] left;
  logic             entry_zero, too_many;

  always_comb begin
    if (run_len_q == '0) begin
      run_lim = (RUN_AW+1)'(1);
    end else if (int'(run_len_q) > RUN_DEPTH) begin
      run_lim = (RUN_AW+1)'(RUN_DEPTH);
    end else begin
      run_lim = (RUN_AW+1)'(run_len_q);
    end
    if (int'(rem_q) < int'(run_lim)) begin
      run_idx = RUN_AW'(rem_q);
    end else begin
      run_idx = RUN_AW'(run_lim - (RUN_AW+1)'(1));
    end
    entry_zero = (run_rd_q.run == '0);
    left       = (run_rd_q.run >= rem_q) ? '0 : rem_q - run_rd_q.run;
    // The last allowed slot turns into an error when zeros are still left.
    too_many   = (left != '0) && (int'(n_q) >= MAX_CODES - 1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_run) begin
      run_mem[RUN_AW'(beat_i.entry_index)] <= '{run: beat_i.entry_run, e: fit};
    end
    if (cmd_i.rd_run) begin
      run_rd_q <= run_mem[run_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      n_q   <= '0;
    end else if (cmd_i.accept && (beat_i.cmd == CMD_RUN)) begin
      rem_q <= beat_i.run_count;
      n_q   <= '0;
    end else if (cmd_i.emit_run) begin
      rem_q <= left;
      n_q   <= n_q + CNT_W'(1);
    end
  end

  // Marker search, one entry per cycle.
  logic [MARKER_W-1:0] marker_q;
  logic [SPC_AW:0]     k_q;
  logic [SPC_AW:0]     spc_lim;
  spc_entry_t          spc_cur;

  always_ff @(posedge clk_i) begin
    if (wr_spc) begin
      spc_tab[SPC_AW'(beat_i.entry_index)] <= '{marker: beat_i.marker_id, e: fit};
    end
    if (cmd_i.accept && (beat_i.cmd == CMD_MARKER)) begin
      marker_q <= beat_i.marker_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.accept) begin
      k_q <= '0;
    end else if (cmd_i.spc_step) begin
      k_q <= k_q + (SPC_AW+1)'(1);
    end
  end

  assign spc_lim = (int'(spc_cnt_q) > SPC_DEPTH) ? (SPC_AW+1)'(SPC_DEPTH)
                                                 : (SPC_AW+1)'(spc_cnt_q);
  assign spc_cur = spc_tab[k_q[SPC_AW-1:0]];

  // Sign and zero flag of the accepted coefficient.
  logic sign_q, coef_zero_q;

  always_ff @(posedge clk_i) begin
    if (rd_mag) begin
      sign_q      <= beat_i.coef_value[COEF_W-1];
      coef_zero_q <= (beat_i.coef_value == '0);
    end
  end

  // Output register.
  logic      out_valid_q;
  out_beat_t out_q, out_d;
  logic      emit;

  assign emit = cmd_i.emit_mag || cmd_i.emit_run || cmd_i.emit_spc;

  always_comb begin
    out_d           = '0;
    out_d.last_code = 1'b1;
    out_d.status    = ST_OK;
    if (cmd_i.emit_mag) begin
      if (coef_zero_q) begin
        out_d.status = ST_ZERO_COEF;
      end else begin
        out_d.code_bits = OUT_BITS_W'({mag_rd_q.code, sign_q});
        out_d.code_size = OUT_SIZE_W'(mag_rd_q.size) + OUT_SIZE_W'(1);
      end
    end else if (cmd_i.emit_run) begin
      if (entry_zero || too_many) begin
        out_d.status = ST_BAD_RUN;
      end else begin
        out_d.code_bits = OUT_BITS_W'(run_rd_q.e.code);
        out_d.code_size = OUT_SIZE_W'(run_rd_q.e.size);
        out_d.last_code = (left == '0);
      end
    end else begin
      if (status_o.spc_hit) begin
        out_d.code_bits = OUT_BITS_W'(spc_cur.e.code);
        out_d.code_size = OUT_SIZE_W'(spc_cur.e.size);
      end else begin
        out_d.status = ST_NO_MARKER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_comb begin
    status_o.out_free    = !out_valid_q || out_ready_i;
    status_o.in_run_zero = (beat_i.run_count == '0);
    status_o.run_last    = entry_zero || too_many || (left == '0);
    status_o.spc_end     = (k_q >= spc_lim);
    status_o.spc_hit     = !status_o.spc_end && (spc_cur.marker == marker_q);
  end

endmodule
